[src/fba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fba_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ADDR_W     = 32;
  localparam int SHIFT_W    = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN = SHIFT_W'(2);
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = SHIFT_W'(12);
  localparam logic [SHIFT_W-1:0] SHIFT_RST = SHIFT_W'(4);
  localparam logic [CNT_W-1:0]   COUNT_MAX = CNT_W'(MAX_BLOCKS);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2,
    OP_RSVD  = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNKNOWN   = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE   = 2'd0,
    REG_SHIFT  = 2'd1,
    REG_BLOCKS = 2'd2,
    REG_NONE   = 2'd3
  } reg_e_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_e_t;

  // region lookup result
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } loc_t;

endpackage

`default_nettype wire

[src/fba_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module fba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/fba_addr_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

module fba_addr_unit (
  input  wire logic [fba_pkg::ADDR_W-1:0]  base,
  input  wire logic [fba_pkg::SHIFT_W-1:0] shift,
  input  wire logic [fba_pkg::CNT_W-1:0]   count,
  input  wire logic [fba_pkg::ADDR_W-1:0]  addr,
  input  wire logic [fba_pkg::IDX_W-1:0]   idx,
  output fba_pkg::loc_t                    loc,
  output logic      [fba_pkg::ADDR_W-1:0]  blk_addr
);
  import fba_pkg::*;

  logic [ADDR_W-1:0] offset;
  logic [ADDR_W-1:0] blk;

  // offset wraps modulo 2^32 so a region may run past the top of memory
  always_comb begin
    offset   = addr - base;
    blk      = offset >> shift;
    loc.hit  = blk < ADDR_W'(count);
    loc.idx  = blk[IDX_W-1:0];
    blk_addr = base + (ADDR_W'(idx) << shift);
  end

endmodule

`default_nettype wire

[src/fixed_block_allocator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// allocate from the free list: accept, then S_POP while the link of the head is read, then the result register
// allocate by bump, free, check: the accepting edge writes the result register
// throughput one item per cycle unless out_stall holds the result; no new item is taken during S_POP
// reset: registers to defaults, free list empty, bump count zero
// the link memory is not cleared; an entry is only read after a free wrote it

module fixed_block_allocator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [1:0]  out_status,
  output logic      [31:0] out_block_address,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import fba_pkg::*;

  logic [ADDR_W-1:0]  base_r;
  logic [SHIFT_W-1:0] shift_r;
  logic [CNT_W-1:0]   blocks_r;

  state_e_t           state_r, state_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic               empty_r, empty_nxt;
  logic [CNT_W-1:0]   bump_r, bump_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_e_t          status_r, status_nxt;
  logic [ADDR_W-1:0]  baddr_r, baddr_nxt;

  logic [SHIFT_W-1:0] eff_shift;
  logic [CNT_W-1:0]   eff_count;
  logic               accept;
  loc_t               loc;
  logic [IDX_W-1:0]   idx_sel;
  logic [ADDR_W-1:0]  blk_addr;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]   link_rd;

  always_comb begin
    if (shift_r < SHIFT_MIN) begin
      eff_shift = SHIFT_MIN;
    end else if (shift_r > SHIFT_MAX) begin
      eff_shift = SHIFT_MAX;
    end else begin
      eff_shift = shift_r;
    end
    eff_count = (blocks_r > COUNT_MAX) ? COUNT_MAX : blocks_r;
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      shift_r  <= SHIFT_RST;
      blocks_r <= COUNT_MAX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_e_t'(cfg_index))
        REG_BASE:   base_r   <= cfg_data;
        REG_SHIFT:  shift_r  <= cfg_data[SHIFT_W-1:0];
        REG_BLOCKS: blocks_r <= cfg_data[CNT_W-1:0];
        REG_NONE:   ;
      endcase
    end
  end

  // pop uses the head index, bump uses the counter
  assign idx_sel = (state_r == S_POP) ? head_r : bump_r[IDX_W-1:0];

  fba_addr_unit u_addr (
    .base     (base_r),
    .shift    (eff_shift),
    .count    (eff_count),
    .addr     (in_address),
    .idx      (idx_sel),
    .loc      (loc),
    .blk_addr (blk_addr)
  );

  assign ram_we    = accept && (op_e_t'(in_opcode) == OP_FREE) && loc.hit;
  // the last entry links to itself
  assign ram_wdata = empty_r ? loc.idx : head_r;

  fba_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (loc.idx),
    .wdata (ram_wdata),
    .raddr (head_r),
    .rdata (link_rd)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    empty_nxt     = empty_r;
    bump_nxt      = bump_r;
    status_nxt    = status_r;
    baddr_nxt     = baddr_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op_e_t'(in_opcode))
            OP_ALLOC: begin
              if (!empty_r) begin
                // link of the head comes back next cycle
                state_nxt = S_POP;
              end else if (bump_r < eff_count) begin
                bump_nxt      = bump_r + CNT_W'(1);
                status_nxt    = ST_OK;
                baddr_nxt     = blk_addr;
                out_valid_nxt = 1'b1;
              end else begin
                status_nxt    = ST_EXHAUSTED;
                baddr_nxt     = '0;
                out_valid_nxt = 1'b1;
              end
            end
            OP_FREE: begin
              if (loc.hit) begin
                head_nxt  = loc.idx;
                empty_nxt = 1'b0;
              end
              status_nxt    = loc.hit ? ST_OK : ST_UNKNOWN;
              baddr_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            OP_CHECK: begin
              status_nxt    = loc.hit ? ST_OK : ST_UNKNOWN;
              baddr_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            OP_RSVD: begin
              status_nxt    = ST_UNKNOWN;
              baddr_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        // result register is empty here: the item was only taken when it was
        if (link_rd == head_r) begin
          empty_nxt = 1'b1;
        end else begin
          head_nxt = link_rd;
        end
        status_nxt    = ST_OK;
        baddr_nxt     = blk_addr;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      empty_r     <= 1'b1;
      bump_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      empty_r     <= empty_nxt;
      bump_r      <= bump_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    baddr_r  <= baddr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_block_address = baddr_r;

endmodule

`default_nettype wire

[sim/fixed_block_allocator_checker.sv]
`timescale 1ns / 1ps

module fixed_block_allocator_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_address,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [1:0]  out_status,
  input  wire logic [31:0] out_block_address,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               fail_count,
  output int               pending
);
  import fba_pkg::*;

  typedef struct packed {
    status_e_t   status;
    logic [31:0] block_address;
  } alloc_reply_t;

  alloc_reply_t reply_q[$];

  // shadow of the pool: free list links, list top, bump counter
  logic [IDX_W-1:0]   next_link [MAX_BLOCKS];
  logic [IDX_W-1:0]   list_top;
  logic               list_empty;
  logic [CNT_W-1:0]   bumped;

  logic [31:0]        base_q;
  logic [SHIFT_W-1:0] shift_q;
  logic [CNT_W-1:0]   blocks_q;

  function automatic logic [SHIFT_W-1:0] eff_shift();
    if (shift_q < SHIFT_MIN) return SHIFT_MIN;
    if (shift_q > SHIFT_MAX) return SHIFT_MAX;
    return shift_q;
  endfunction

  function automatic logic [CNT_W-1:0] eff_count();
    return (blocks_q > COUNT_MAX) ? COUNT_MAX : blocks_q;
  endfunction

  function automatic alloc_reply_t predict_reply(input logic [1:0] op, input logic [31:0] addr);
    alloc_reply_t     r;
    logic [31:0]      blk;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] nxt;
    r.status = ST_UNKNOWN;
    r.block_address = '0;
    // offset wraps modulo 2^32, so a region may run past the top of memory
    blk = (addr - base_q) >> eff_shift();
    case (op)
      OP_ALLOC: begin
        if (!list_empty) begin
          idx = list_top;
          nxt = next_link[list_top];
          // a self link marks the bottom of the list
          if (nxt == list_top) list_empty = 1'b1;
          else list_top = nxt;
          r.status = ST_OK;
          r.block_address = base_q + (32'(idx) << eff_shift());
        end else if (bumped < eff_count()) begin
          r.status = ST_OK;
          r.block_address = base_q + (32'(bumped) << eff_shift());
          bumped = bumped + 1'b1;
        end else begin
          r.status = ST_EXHAUSTED;
        end
      end
      OP_FREE: begin
        if (blk < 32'(eff_count())) begin
          idx = blk[IDX_W-1:0];
          next_link[idx] = list_empty ? idx : list_top;
          list_top = idx;
          list_empty = 1'b0;
          r.status = ST_OK;
        end
      end
      OP_CHECK: begin
        if (blk < 32'(eff_count())) r.status = ST_OK;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    alloc_reply_t want;
    if (!rst_n) begin
      list_top = '0;
      list_empty = 1'b1;
      bumped = '0;
      base_q = '0;
      shift_q = SHIFT_RST;
      blocks_q = COUNT_MAX;
      reply_q.delete();
    end else begin
      // results first: an item taken at this edge cannot answer at the same edge
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected item, status %0d block_address %h",
                   $time, out_status, out_block_address);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, out_status);
            fail_count++;
          end
          if (out_block_address !== want.block_address) begin
            $display("%0t: block_address mismatch, expected %h actual %h",
                     $time, want.block_address, out_block_address);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) reply_q.push_back(predict_reply(in_opcode, in_address));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE:   base_q = cfg_data;
          REG_SHIFT:  shift_q = cfg_data[SHIFT_W-1:0];
          REG_BLOCKS: blocks_q = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
    pending = reply_q.size();
  end

endmodule

[sim/fixed_block_allocator_unit_tb.sv]
`timescale 1ns / 1ps

module fixed_block_allocator_unit_tb;
  import fba_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [31:0] in_address;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [31:0] out_block_address;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;
  bit holding = 1'b0;

  // current register values, used to aim addresses at the region
  logic [31:0]        cur_base = '0;
  logic [SHIFT_W-1:0] cur_shift = SHIFT_RST;
  logic [CNT_W-1:0]   cur_blocks = COUNT_MAX;

  fixed_block_allocator_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_address        (in_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_block_address (out_block_address),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  fixed_block_allocator_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_address        (in_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_block_address (out_block_address),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SHIFT_W-1:0] region_shift();
    if (cur_shift < SHIFT_MIN) return SHIFT_MIN;
    if (cur_shift > SHIFT_MAX) return SHIFT_MAX;
    return cur_shift;
  endfunction

  function automatic logic [CNT_W-1:0] region_count();
    return (cur_blocks > COUNT_MAX) ? COUNT_MAX : cur_blocks;
  endfunction

  function automatic logic [31:0] region_addr(input bit misalign);
    logic [31:0]        idx;
    logic [31:0]        off;
    logic [SHIFT_W-1:0] s;
    logic [CNT_W-1:0]   c;
    s = region_shift();
    c = region_count();
    if (c == 0) return $urandom;
    idx = $urandom_range(0, c - 1);
    off = misalign ? ($urandom & ((32'd1 << s) - 1)) : 32'd0;
    return cur_base + (idx << s) + off;
  endfunction

  // first and last bytes of the region and their outside neighbors
  function automatic logic [31:0] edge_addr();
    logic [31:0] span;
    span = 32'(region_count()) << region_shift();
    case ($urandom_range(0, 3))
      0: return cur_base;
      1: return cur_base - 1;
      2: return cur_base + span - 1;
      default: return cur_base + span;
    endcase
  endfunction

  function automatic void pick_item(input int alloc_pct, output logic [1:0] op,
                                    output logic [31:0] addr);
    int r;
    r = $urandom_range(0, 99);
    addr = $urandom;
    if (r < alloc_pct) begin
      op = OP_ALLOC;
    end else if (r < alloc_pct + 30) begin
      op = OP_FREE;
      if ($urandom_range(0, 7) != 0) addr = region_addr($urandom_range(0, 3) == 0);
    end else if (r < 96) begin
      op = OP_CHECK;
      case ($urandom_range(0, 2))
        0: addr = region_addr(1'b1);
        1: addr = edge_addr();
        default: ;
      endcase
    end else begin
      op = OP_RSVD;
    end
  endfunction

  task automatic send(input logic [1:0] op, input logic [31:0] addr);
    in_opcode <= op;
    in_address <= addr;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic run_one(input logic [1:0] op, input logic [31:0] addr);
    send(op, addr);
    pause_sender(gap_len());
  endtask

  task automatic run_random(input int n, input int alloc_pct);
    logic [1:0]  op;
    logic [31:0] addr;
    repeat (n) begin
      pick_item(alloc_pct, op, addr);
      run_one(op, addr);
    end
  endtask

  // one edge first so the item taken at this edge is already counted
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_e_t idx, input logic [31:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic reconfigure(input logic [31:0] base, input logic [SHIFT_W-1:0] shift,
                             input logic [CNT_W-1:0] blocks);
    drain();
    write_reg(REG_BASE, base);
    write_reg(REG_SHIFT, 32'(shift));
    write_reg(REG_BLOCKS, 32'(blocks));
    cfg_valid <= 1'b0;
    cur_base = base;
    cur_shift = shift;
    cur_blocks = blocks;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0]  op;
    logic [31:0] addr;
    int          pct;
    in_valid <= 1'b0;
    in_opcode <= OP_ALLOC;
    in_address <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_BASE;
    cfg_data <= '0;
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: 1024 blocks of 16 bytes at address zero
    run_one(OP_CHECK, 32'h0000_0000);
    run_one(OP_CHECK, 32'h0000_3FFF);
    run_one(OP_CHECK, 32'h0000_4000);
    run_one(OP_CHECK, 32'hFFFF_FFFF);
    repeat (3) run_one(OP_ALLOC, $urandom);
    run_one(OP_FREE, 32'h0000_0015);      // misaligned, truncates to block 1
    run_one(OP_FREE, 32'h0000_0000);
    run_one(OP_FREE, 32'h0000_0000);      // double free
    run_one(OP_FREE, 32'h0004_0000);      // outside the region
    run_one(OP_FREE, 32'h0000_0030);      // never handed out
    run_one(OP_RSVD, 32'hFFFF_FFFF);
    repeat (5) run_one(OP_ALLOC, 32'h0000_0000);

    // empty region, shift below range: out of blocks
    reconfigure(32'hFFFF_FFF8, 4'd0, 11'd0);
    run_one(OP_CHECK, 32'hFFFF_FFF8);
    run_one(OP_ALLOC, 32'h0000_0000);
    run_one(OP_FREE, 32'hFFFF_FFF8);

    // small region wrapping through zero, bump counter already past it
    reconfigure(32'hFFFF_FFF8, 4'd2, 11'd4);
    run_one(OP_CHECK, 32'h0000_0007);
    run_one(OP_CHECK, 32'h0000_0008);
    run_one(OP_ALLOC, 32'h0000_0000);
    run_one(OP_FREE, 32'h0000_0006);
    run_one(OP_ALLOC, 32'h0000_0000);

    // shift and count above range
    reconfigure(32'h1234_5000, 4'd15, 11'd2047);
    run_one(OP_CHECK, 32'h1274_4FFF);
    run_one(OP_ALLOC, 32'h0000_0000);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          reconfigure($urandom, 4'd2, 11'd1);
          pct = 50;
        end
        1: begin
          reconfigure(32'hFFFF_FFFF, 4'd12, 11'd1024);
          pct = 45;
        end
        2: begin
          reconfigure($urandom, 4'd15, 11'd0);
          pct = 40;
        end
        3: begin
          reconfigure($urandom, SHIFT_W'($urandom_range(2, 12)),
                      CNT_W'($urandom_range(1, 64)));
          pct = 50;
        end
        4: begin
          reconfigure(32'h0000_0000, 4'd0, 11'd2047);
          pct = 40;
        end
        5: begin
          reconfigure($urandom, SHIFT_W'($urandom_range(0, 15)),
                      CNT_W'($urandom_range(0, 2047)));
          pct = 45;
        end
        6: begin
          reconfigure($urandom, 4'd4, 11'd16);
          pct = 58;
        end
        default: begin
          reconfigure($urandom, SHIFT_W'($urandom_range(2, 12)), 11'd3);
          pct = 50;
        end
      endcase
      no_gaps = (ph == 2) || (ph == 6);
      if (ph == 3) begin
        run_random(40, pct);
        // keep offering while the receiver holds off, so the block backs up
        hold_req = 1'b1;
        wait (holding);
        repeat (40) begin
          pick_item(pct, op, addr);
          send(op, addr);
        end
        run_random(50, pct);
      end else if (ph == 5) begin
        run_random(65, pct);
        drain();
        run_random(65, pct);
      end else begin
        run_random(130, pct);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
